FILE: src/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan pressure regulator package
// Shared types, register indexes, reset values and constants of the regulator.
// ----------------------------------------------------------------------------
package fpr_pkg;

	// Width of the tick arithmetic; sums wrap at this width.
	localparam int TICK_BITS = 32;
	// Width of the tick field on the input channel.
	localparam int TICK_IN_W = 32;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQUENCY     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET        = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND          = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN         = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_PER_UNIT     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_STEP       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_FREQUENCY = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_THRESHOLD   = 4'd7;

	// Register reset values.
	localparam logic [15:0] RST_MAX_FREQUENCY     = 16'd20000;
	localparam logic [9:0]  RST_MAX_TARGET        = 10'd120;
	localparam logic [7:0]  RST_DEADBAND          = 8'd1;
	localparam logic [7:0]  RST_LOOP_GAIN         = 8'd40;
	localparam logic [9:0]  RST_WAIT_PER_UNIT     = 10'd80;
	localparam logic [15:0] RST_MANUAL_STEP       = 16'd200;
	localparam logic [15:0] RST_MIN_RUN_FREQUENCY = 16'd1200;
	localparam logic [15:0] RST_BURST_THRESHOLD   = 16'd4000;

	// Error stored after a burst, which stretches the next wait.
	localparam logic signed [15:0] BURST_WAIT_ERROR = 16'sd60;
	// Ticks the target-setting display stays up after the last key input.
	localparam int SET_SCREEN_TICKS = 1000;

	typedef logic [TICK_BITS-1:0] tick_t;

	typedef struct packed {
		logic [15:0] max_frequency;
		logic [9:0]  max_target;
		logic [7:0]  deadband;
		logic [7:0]  loop_gain;
		logic [9:0]  wait_per_unit;
		logic [15:0] manual_step;
		logic [15:0] min_run_frequency;
		logic [15:0] burst_threshold;
	} cfg_t;

	typedef struct packed {
		logic [TICK_IN_W-1:0] tick;
		logic signed [15:0]   pressure;
		logic [15:0]          fan_reported_freq;
		logic                 mode_toggle;
		logic                 down_event;
		logic                 up_event;
		logic                 key_held;
	} item_t;

	typedef struct packed {
		logic [15:0] freq_command;
		logic        auto_mode;
		logic [9:0]  target_now;
		logic        set_screen;
	} result_t;

endpackage

FILE: src/fpr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan pressure regulator channels
// Valid/ready channels for loop pass items, result items and register writes.
// ----------------------------------------------------------------------------

// One loop pass item.
interface fpr_item_if;
	logic                          valid;
	logic                          ready;
	logic [fpr_pkg::TICK_IN_W-1:0] tick;
	logic signed [15:0]            pressure;
	logic [15:0]                   fan_reported_freq;
	logic                          mode_toggle;
	logic                          down_event;
	logic                          up_event;
	logic                          key_held;

	modport source (output valid, tick, pressure, fan_reported_freq, mode_toggle,
		down_event, up_event, key_held, input ready);
	modport sink (input valid, tick, pressure, fan_reported_freq, mode_toggle,
		down_event, up_event, key_held, output ready);
endinterface

// One result item.
interface fpr_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] freq_command;
	logic        auto_mode;
	logic [9:0]  target_now;
	logic        set_screen;

	modport source (output valid, freq_command, auto_mode, target_now, set_screen,
		input ready);
	modport sink (input valid, freq_command, auto_mode, target_now, set_screen,
		output ready);
endinterface

// Register write channel.
interface fpr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fpr_pkg::CFG_IDX_W-1:0]  index;
	logic [fpr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/fan_pressure_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan pressure regulator
// Manual and automatic fan frequency control of a pressure loop, one loop
// pass per item.
// ----------------------------------------------------------------------------
// Each accepted item is one loop pass and yields exactly one result item.
// The block takes one item per clock cycle when the result side keeps up;
// a result item passes the input register, then the result register,
// before it is offered. The core updates the loop state once per item,
// from the registered item. An input item is still taken while a finished
// result waits, if the input register is empty, as the input and result
// registers part the two sides. Register writes are always accepted and are
// to be made while no item is in flight.
module fan_pressure_regulator (
	input  logic       clk,
	input  logic       arst_n,
	fpr_item_if.sink   sample,
	fpr_result_if.source result,
	fpr_cfg_if.sink    cfg
);

	fpr_pkg::cfg_t    regs;
	fpr_pkg::item_t   item_s1;
	logic             s1_valid_q;
	fpr_pkg::result_t res_c;
	fpr_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;
	logic             in_accept;

	fpr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	fpr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (regs),
		.res     (res_c)
	);

	// Handshake: the input stage moves on when the result register is free or its result is taken.
	assign advance      = s1_valid_q && (!out_valid_q || result.ready);
	assign sample.ready = !s1_valid_q || advance;
	assign in_accept    = sample.valid && sample.ready;

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.tick              <= sample.tick;
			item_s1.pressure          <= sample.pressure;
			item_s1.fan_reported_freq <= sample.fan_reported_freq;
			item_s1.mode_toggle       <= sample.mode_toggle;
			item_s1.down_event        <= sample.down_event;
			item_s1.up_event          <= sample.up_event;
			item_s1.key_held          <= sample.key_held;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.freq_command = res_q.freq_command;
	assign result.auto_mode    = res_q.auto_mode;
	assign result.target_now   = res_q.target_now;
	assign result.set_screen   = res_q.set_screen;

`ifndef SYNTHESIS
	// The input side stalls only when both stages are full and the result waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> s1_valid_q && out_valid_q && !result.ready)
		else $error("input stalled without a full pipeline");

	// A result only appears after an item left the input stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("result shown with no item behind it");
`endif

endmodule

FILE: src/fpr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan pressure regulator configuration registers
// Decodes register writes and holds the loop settings.
// ----------------------------------------------------------------------------
module fpr_cfg (
	input  logic             clk,
	input  logic             arst_n,
	fpr_cfg_if.sink          cfg,
	output fpr_pkg::cfg_t    regs
);

	fpr_pkg::cfg_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register file; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_frequency     <= fpr_pkg::RST_MAX_FREQUENCY;
			regs_q.max_target        <= fpr_pkg::RST_MAX_TARGET;
			regs_q.deadband          <= fpr_pkg::RST_DEADBAND;
			regs_q.loop_gain         <= fpr_pkg::RST_LOOP_GAIN;
			regs_q.wait_per_unit     <= fpr_pkg::RST_WAIT_PER_UNIT;
			regs_q.manual_step       <= fpr_pkg::RST_MANUAL_STEP;
			regs_q.min_run_frequency <= fpr_pkg::RST_MIN_RUN_FREQUENCY;
			regs_q.burst_threshold   <= fpr_pkg::RST_BURST_THRESHOLD;
		end else if (cfg.valid) begin
			case (cfg.index)
				fpr_pkg::REG_MAX_FREQUENCY:     regs_q.max_frequency     <= cfg.data;
				fpr_pkg::REG_MAX_TARGET:        regs_q.max_target        <= cfg.data[9:0];
				fpr_pkg::REG_DEADBAND:          regs_q.deadband          <= cfg.data[7:0];
				fpr_pkg::REG_LOOP_GAIN:         regs_q.loop_gain         <= cfg.data[7:0];
				fpr_pkg::REG_WAIT_PER_UNIT:     regs_q.wait_per_unit     <= cfg.data[9:0];
				fpr_pkg::REG_MANUAL_STEP:       regs_q.manual_step       <= cfg.data;
				fpr_pkg::REG_MIN_RUN_FREQUENCY: regs_q.min_run_frequency <= cfg.data;
				fpr_pkg::REG_BURST_THRESHOLD:   regs_q.burst_threshold   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: src/fpr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan pressure regulator core
// Holds the loop state and computes one loop pass from the registered item.
// ----------------------------------------------------------------------------
module fpr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  fpr_pkg::item_t   item,
	input  fpr_pkg::cfg_t    cfg,
	output fpr_pkg::result_t res
);

	// Loop state.
	logic                  mode_q;
	logic [15:0]           held_q;
	logic [9:0]            target_q;
	logic signed [15:0]    last_err_q;
	fpr_pkg::tick_t        adjust_q;
	fpr_pkg::tick_t        input_q;

	// Next state.
	logic                  mode_nx;
	logic [15:0]           held_nx;
	logic [9:0]            target_nx;
	logic signed [15:0]    last_err_nx;
	fpr_pkg::tick_t        adjust_nx;
	fpr_pkg::tick_t        input_nx;

	// Manual path.
	logic signed [17:0]    man_f;
	logic [15:0]           man_cmd;

	// Automatic path.
	fpr_pkg::tick_t        tick_c;
	logic [9:0]            t_dn;
	logic [9:0]            t_new;
	logic [15:0]           mag;
	logic [25:0]           wait_prod;
	fpr_pkg::tick_t        due;
	logic                  is_due;
	logic signed [16:0]    err;
	logic signed [16:0]    db_s;
	logic signed [15:0]    err_sat;
	logic                  outside;
	logic signed [25:0]    corr;
	logic signed [26:0]    sum;
	logic [15:0]           sum_clamped;
	logic [15:0]           adj;
	logic                  burst;
	logic [15:0]           auto_f;
	logic                  screen;

	assign mode_nx = mode_q ^ item.mode_toggle;
	assign tick_c  = fpr_pkg::TICK_BITS'(item.tick);

	// Manual stepping of the held frequency, clamped to 0..max_frequency.
	always_comb begin
		man_f = $signed({2'b00, held_q});
		if (item.down_event) begin
			man_f = man_f - $signed({2'b00, cfg.manual_step});
		end
		if (item.up_event) begin
			man_f = man_f + $signed({2'b00, cfg.manual_step});
		end
		if (man_f < 18'sd0) begin
			man_cmd = '0;
		end else if (man_f > $signed({2'b00, cfg.max_frequency})) begin
			man_cmd = cfg.max_frequency;
		end else begin
			man_cmd = man_f[15:0];
		end
	end

	// Target stepping while a key is held in automatic mode.
	always_comb begin
		t_dn  = (target_q != 10'd0 && item.down_event) ? target_q - 10'd1 : target_q;
		t_new = (t_dn < cfg.max_target && item.up_event) ? t_dn + 10'd1 : t_dn;
		target_nx = (mode_nx && item.key_held) ? t_new : target_q;
		input_nx  = (mode_nx && item.key_held) ? tick_c : input_q;
	end

	// Wait before the next adjustment grows with the last error.
	always_comb begin
		mag       = last_err_q[15] ? 16'(-last_err_q) : 16'(last_err_q);
		wait_prod = 26'(mag) * 26'(cfg.wait_per_unit);
		due       = adjust_q + fpr_pkg::TICK_BITS'(wait_prod);
		is_due    = tick_c >= due;
	end

	// Error, deadband test and proportional correction.
	always_comb begin
		err     = $signed({7'b0, target_nx}) - $signed({item.pressure[15], item.pressure});
		db_s    = $signed({9'b0, cfg.deadband});
		err_sat = (err > 17'sd32767) ? 16'sh7fff : err[15:0];
		outside = (err < -db_s) || (err > db_s);
		corr    = err * $signed({1'b0, cfg.loop_gain});
		sum     = $signed({11'b0, item.fan_reported_freq}) + 27'(corr);
		if (sum < 27'sd0) begin
			sum_clamped = '0;
		end else if (sum > $signed({11'b0, cfg.max_frequency})) begin
			sum_clamped = cfg.max_frequency;
		end else begin
			sum_clamped = sum[15:0];
		end
		adj   = outside ? sum_clamped : item.fan_reported_freq;
		burst = adj < cfg.burst_threshold;
	end

	// Automatic frequency, burst handling and the stored error.
	always_comb begin
		auto_f      = item.fan_reported_freq;
		last_err_nx = last_err_q;
		adjust_nx   = adjust_q;
		if (mode_nx && is_due) begin
			adjust_nx   = tick_c;
			last_err_nx = err_sat;
			auto_f      = adj;
			if (burst) begin
				last_err_nx = fpr_pkg::BURST_WAIT_ERROR;
				if (target_nx < {2'b00, cfg.deadband}) begin
					auto_f = '0;
				end else if (adj < cfg.min_run_frequency) begin
					auto_f = cfg.min_run_frequency;
				end
			end
		end
		screen  = !(tick_c > (input_nx + fpr_pkg::TICK_BITS'(fpr_pkg::SET_SCREEN_TICKS)));
		held_nx = mode_nx ? auto_f : item.fan_reported_freq;
	end

	// Result of this pass.
	assign res.freq_command = mode_nx ? auto_f : man_cmd;
	assign res.auto_mode    = mode_nx;
	assign res.target_now   = target_nx;
	assign res.set_screen   = mode_nx & screen;

	// State update, once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			held_q     <= '0;
			target_q   <= '0;
			last_err_q <= '0;
			adjust_q   <= '0;
			input_q    <= '0;
		end else if (step_en) begin
			mode_q     <= mode_nx;
			held_q     <= held_nx;
			target_q   <= target_nx;
			last_err_q <= last_err_nx;
			adjust_q   <= adjust_nx;
			input_q    <= input_nx;
		end
	end

`ifndef SYNTHESIS
	// The target moves by at most one per item.
	a_target_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> (target_q == $past(target_q) || target_q == $past(target_q) + 10'd1 ||
			target_q == $past(target_q) - 10'd1))
		else $error("target moved by more than one step");

	// A manual command stays within the frequency clamp.
	a_manual_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !res.auto_mode |-> res.freq_command <= cfg.max_frequency)
		else $error("manual command above max_frequency");

	// In manual mode the held frequency follows the fan's report.
	a_manual_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !res.auto_mode |=> held_q == $past(item.fan_reported_freq))
		else $error("held frequency did not take the reported value");
`endif

endmodule

FILE: verif/fpr_loop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan pressure regulator loop checker
// Watches the item, result and register channels of the regulator. It keeps
// its own copy of the loop state and the registers, works out the result item
// of every accepted loop pass, and compares each accepted result item field
// by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module fpr_loop_checker
	import fpr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	fpr_item_if   sample,
	fpr_result_if result,
	fpr_cfg_if    cfg,
	output int    errors,
	output int    pending
);

	// Register copy and loop state as the block should hold them.
	cfg_t              settings;
	logic              auto_flag;
	logic [15:0]       held_freq;
	logic [9:0]        target_pa;
	logic signed [15:0] last_err;
	tick_t             last_adjust_tick;
	tick_t             last_input_tick;

	// Result items predicted but not yet seen, oldest first.
	result_t expected_passes[$];
	int      results_seen;

	// Print one line per failure and count it.
	task automatic report_failure(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Clamp a frequency to 0..max_frequency.
	function automatic longint clamp_to_max(input longint f);
		if (f < 0)
			return 0;
		if (f > longint'(settings.max_frequency))
			return longint'(settings.max_frequency);
		return f;
	endfunction

	// Run one loop pass on the local state and return the result item it yields.
	function automatic result_t predict_pass(input item_t it);
		result_t     r;
		longint      f;
		longint      err;
		longint      mag;
		tick_t       tk;
		tick_t       due;
		tk = tick_t'(it.tick);
		r.set_screen = 1'b0;
		if (it.mode_toggle)
			auto_flag = ~auto_flag;
		if (!auto_flag) begin
			// Manual: step from the held frequency (the fan's last report, or the last automatic command).
			f = longint'(held_freq);
			if (it.down_event)
				f -= longint'(settings.manual_step);
			if (it.up_event)
				f += longint'(settings.manual_step);
			f = clamp_to_max(f);
			held_freq = it.fan_reported_freq;
		end else begin
			f = longint'(it.fan_reported_freq);
			// Target setting while a key is held.
			if (it.key_held) begin
				if (target_pa > 0 && it.down_event)
					target_pa = target_pa - 1'b1;
				if (target_pa < settings.max_target && it.up_event)
					target_pa = target_pa + 1'b1;
				last_input_tick = tk;
			end
			// The wait after an adjustment grows with the size of the last error.
			mag = (last_err < 0) ? -longint'(last_err) : longint'(last_err);
			due = last_adjust_tick + tick_t'(mag * longint'(settings.wait_per_unit));
			if (tk >= due) begin
				err = longint'(target_pa) - longint'($signed(it.pressure));
				last_adjust_tick = tk;
				if (err > 32767)
					last_err = 16'sh7FFF;
				else if (err < -32768)
					last_err = 16'sh8000;
				else
					last_err = 16'(err);
				if (err < -longint'(settings.deadband) || err > longint'(settings.deadband))
					f = clamp_to_max(f + err * longint'(settings.loop_gain));
				// Burst handling: stretch the next wait and stop or lift the fan.
				if (f < longint'(settings.burst_threshold)) begin
					last_err = BURST_WAIT_ERROR;
					if (int'(target_pa) < int'(settings.deadband))
						f = 0;
					else if (f < longint'(settings.min_run_frequency))
						f = longint'(settings.min_run_frequency);
				end
			end
			held_freq = 16'(f);
			r.set_screen = (tk > tick_t'(last_input_tick + SET_SCREEN_TICKS)) ? 1'b0 : 1'b1;
		end
		r.freq_command = 16'(f);
		r.auto_mode = auto_flag;
		r.target_now = target_pa;
		return r;
	endfunction

	// Follow the three channels; results are checked before a new item is predicted.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		item_t   pass;
		if (!arst_n) begin
			settings.max_frequency = RST_MAX_FREQUENCY;
			settings.max_target = RST_MAX_TARGET;
			settings.deadband = RST_DEADBAND;
			settings.loop_gain = RST_LOOP_GAIN;
			settings.wait_per_unit = RST_WAIT_PER_UNIT;
			settings.manual_step = RST_MANUAL_STEP;
			settings.min_run_frequency = RST_MIN_RUN_FREQUENCY;
			settings.burst_threshold = RST_BURST_THRESHOLD;
			auto_flag = 1'b0;
			held_freq = '0;
			target_pa = '0;
			last_err = '0;
			last_adjust_tick = '0;
			last_input_tick = '0;
			expected_passes.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_MAX_FREQUENCY:     settings.max_frequency = cfg.data[15:0];
				REG_MAX_TARGET:        settings.max_target = cfg.data[9:0];
				REG_DEADBAND:          settings.deadband = cfg.data[7:0];
				REG_LOOP_GAIN:         settings.loop_gain = cfg.data[7:0];
				REG_WAIT_PER_UNIT:     settings.wait_per_unit = cfg.data[9:0];
				REG_MANUAL_STEP:       settings.manual_step = cfg.data[15:0];
				REG_MIN_RUN_FREQUENCY: settings.min_run_frequency = cfg.data[15:0];
				REG_BURST_THRESHOLD:   settings.burst_threshold = cfg.data[15:0];
				default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_passes.size() == 0) begin
					report_failure($sformatf("result item %0d arrived with none expected",
						results_seen));
				end else begin
					want = expected_passes.pop_front();
					if (result.freq_command !== want.freq_command)
						report_failure($sformatf("result %0d freq_command %0d, expected %0d",
							results_seen, result.freq_command, want.freq_command));
					if (result.auto_mode !== want.auto_mode)
						report_failure($sformatf("result %0d auto_mode %0b, expected %0b",
							results_seen, result.auto_mode, want.auto_mode));
					if (result.target_now !== want.target_now)
						report_failure($sformatf("result %0d target_now %0d, expected %0d",
							results_seen, result.target_now, want.target_now));
					if (result.set_screen !== want.set_screen)
						report_failure($sformatf("result %0d set_screen %0b, expected %0b",
							results_seen, result.set_screen, want.set_screen));
				end
				results_seen++;
			end
			if (sample.valid && sample.ready) begin
				pass.tick = sample.tick;
				pass.pressure = sample.pressure;
				pass.fan_reported_freq = sample.fan_reported_freq;
				pass.mode_toggle = sample.mode_toggle;
				pass.down_event = sample.down_event;
				pass.up_event = sample.up_event;
				pass.key_held = sample.key_held;
				expected_passes.push_back(predict_pass(pass));
			end
		end
		pending = expected_passes.size();
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan pressure regulator testbench
// Drives loop pass items and register writes into the regulator with random
// bursts and gaps, stalls the result side, and lets the loop checker judge
// every result item. A directed run over the corner cases comes first, then
// phases of random passes under different register settings.
// ----------------------------------------------------------------------------
module testbench;
	import fpr_pkg::*;

	localparam int ITEMS_PER_PHASE = 150;
	localparam int QUIET_LIMIT = 2000;

	typedef enum {SET_RESET, SET_HIGH, SET_LOW, SET_MIN_OVER_MAX, SET_TYPICAL, SET_ANY}
		settings_style_t;
	typedef enum {READY_ALWAYS, READY_RANDOM, READY_BLOCKS} ready_style_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   quiet_cycles;
	int   burst_left;

	fpr_item_if   sample_ch();
	fpr_result_if result_ch();
	fpr_cfg_if    cfg_ch();

	fan_pressure_regulator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	fpr_loop_checker pass_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one loop pass item and hold it until taken; gaps follow each burst.
	task automatic send_pass(input logic [31:0] tk, input logic signed [15:0] pa,
			input logic [15:0] rep, input logic tg, input logic dn, input logic upv,
			input logic hd);
		int gap;
		sample_ch.tick <= tk;
		sample_ch.pressure <= pa;
		sample_ch.fan_reported_freq <= rep;
		sample_ch.mode_toggle <= tg;
		sample_ch.down_event <= dn;
		sample_ch.up_event <= upv;
		sample_ch.key_held <= hd;
		sample_ch.valid <= 1'b1;
		do @(posedge clk); while (!sample_ch.ready);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
		end
	endtask

	// One register write; the write channel is left idle before the task returns.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering items and wait until every result item is back.
	task automatic settle_until_idle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	// Result side: the stall style is drawn at random and redrawn when its run ends.
	initial begin : result_stall
		ready_style_t style;
		int style_left;
		int hold;
		style = READY_ALWAYS;
		style_left = 0;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				style = ready_style_t'($urandom_range(0, 2));
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			case (style)
			READY_ALWAYS: result_ch.ready <= 1'b1;
			READY_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (hold <= 0) begin
					hold = $urandom_range(1, 12);
					result_ch.ready <= ~result_ch.ready;
				end
				hold--;
			end
			endcase
		end
	end

	// Watchdog: end the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed corner cases, then random phases, then the verdict.
	initial begin : stimulus
		settings_style_t phase_plan[10];
		cfg_t            regs;
		logic [31:0]     cur_tick;
		int              press_center;
		int              pick;
		logic signed [15:0] pa;
		logic [15:0]     rep;
		phase_plan = '{SET_RESET, SET_TYPICAL, SET_HIGH, SET_TYPICAL, SET_LOW,
			SET_MIN_OVER_MAX, SET_ANY, SET_TYPICAL, SET_ANY, SET_HIGH};
		burst_left = 3;
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.tick <= '0;
		sample_ch.pressure <= '0;
		sample_ch.fan_reported_freq <= '0;
		sample_ch.mode_toggle <= 1'b0;
		sample_ch.down_event <= 1'b0;
		sample_ch.up_event <= 1'b0;
		sample_ch.key_held <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Manual mode: clamp at zero, step up, clamp at the maximum, opposite events.
		send_pass(32'd0, 16'sd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
		send_pass(32'd1, 16'sh7FFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0);
		send_pass(32'd2, 16'sh8000, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1);
		send_pass(32'd3, 16'sd0, 16'd100, 1'b0, 1'b1, 1'b1, 1'b0);
		// Into automatic mode with a zero target: the burst stops the fan.
		send_pass(32'd10, 16'sd0, 16'd2000, 1'b1, 1'b0, 1'b0, 1'b1);
		// Raise the target while the wait is still running.
		send_pass(32'd20, 16'sd0, 16'd7000, 1'b0, 1'b0, 1'b1, 1'b1);
		send_pass(32'd30, 16'sd0, 16'd7000, 1'b0, 1'b0, 1'b1, 1'b1);
		send_pass(32'd40, 16'sd0, 16'd7000, 1'b0, 1'b0, 1'b1, 1'b1);
		send_pass(32'd50, 16'sd0, 16'd7000, 1'b0, 1'b0, 1'b1, 1'b1);
		// Huge positive error: stored error saturates, frequency clamps high.
		send_pass(32'd5000, 16'sh8000, 16'd10000, 1'b0, 1'b0, 1'b0, 1'b0);
		// Long wait not yet over; the set screen has timed out.
		send_pass(32'd6000, 16'sd0, 16'd3000, 1'b0, 1'b0, 1'b0, 1'b0);
		// Huge negative error at the top tick: burst lifts to the minimum.
		send_pass(32'hFFFF_FFFF, 16'sh7FFF, 16'd15000, 1'b0, 1'b0, 1'b0, 1'b0);
		// Due tick wraps past zero; error within the deadband.
		send_pass(32'd4800, 16'sd5, 16'd2000, 1'b0, 1'b0, 1'b0, 1'b0);
		// Key input near the top of the tick range, then the screen after the wrap.
		send_pass(32'hFFFF_FF00, 16'sd4, 16'd9000, 1'b0, 1'b0, 1'b0, 1'b1);
		send_pass(32'd100, 16'sd4, 16'd9000, 1'b0, 1'b0, 1'b0, 1'b0);
		// Back to manual: the held frequency is the last automatic command.
		send_pass(32'd101, 16'sd0, 16'd300, 1'b1, 1'b0, 1'b0, 1'b0);
		settle_until_idle();

		// Minimum running frequency above the maximum, target above its new limit.
		write_reg(REG_MAX_FREQUENCY, 16'd1000);
		write_reg(REG_MIN_RUN_FREQUENCY, 16'd3000);
		write_reg(REG_MAX_TARGET, 16'd2);
		send_pass(32'h1000_0000, 16'sd4, 16'd500, 1'b1, 1'b0, 1'b1, 1'b1);
		send_pass(32'h2000_0000, 16'sd0, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1);
		settle_until_idle();

		// Random phases, each under its own register settings.
		foreach (phase_plan[p]) begin
			case (phase_plan[p])
			SET_RESET: begin
				regs.max_frequency = RST_MAX_FREQUENCY;
				regs.max_target = RST_MAX_TARGET;
				regs.deadband = RST_DEADBAND;
				regs.loop_gain = RST_LOOP_GAIN;
				regs.wait_per_unit = RST_WAIT_PER_UNIT;
				regs.manual_step = RST_MANUAL_STEP;
				regs.min_run_frequency = RST_MIN_RUN_FREQUENCY;
				regs.burst_threshold = RST_BURST_THRESHOLD;
			end
			SET_HIGH: begin
				regs.max_frequency = 16'hFFFF;
				regs.max_target = 10'd1000;
				regs.deadband = 8'hFF;
				regs.loop_gain = 8'hFF;
				regs.wait_per_unit = 10'd1023;
				regs.manual_step = 16'hFFFF;
				regs.min_run_frequency = 16'hFFFF;
				regs.burst_threshold = 16'hFFFF;
			end
			SET_LOW: regs = '0;
			SET_ANY: begin
				regs.max_frequency = 16'($urandom_range(0, 65535));
				regs.max_target = 10'($urandom_range(0, 1000));
				regs.deadband = 8'($urandom_range(0, 255));
				regs.loop_gain = 8'($urandom_range(0, 255));
				regs.wait_per_unit = 10'($urandom_range(0, 1023));
				regs.manual_step = 16'($urandom_range(0, 65535));
				regs.min_run_frequency = 16'($urandom_range(0, 65535));
				regs.burst_threshold = 16'($urandom_range(0, 65535));
			end
			default: begin
				regs.max_frequency = 16'($urandom_range(8000, 65535));
				regs.max_target = 10'($urandom_range(20, 1000));
				regs.deadband = 8'($urandom_range(0, 8));
				regs.loop_gain = 8'($urandom_range(0, 255));
				regs.wait_per_unit = 10'($urandom_range(0, 30));
				regs.manual_step = 16'($urandom_range(0, 5000));
				regs.min_run_frequency = 16'($urandom_range(0, 6000));
				regs.burst_threshold = 16'($urandom_range(0, 8000));
				if (phase_plan[p] == SET_MIN_OVER_MAX) begin
					regs.max_frequency = 16'($urandom_range(0, 3000));
					regs.min_run_frequency = 16'($urandom_range(3001, 65535));
					regs.burst_threshold = 16'($urandom_range(0, 65535));
				end
			end
			endcase
			write_reg(REG_MAX_FREQUENCY, regs.max_frequency);
			write_reg(REG_MAX_TARGET, 16'(regs.max_target));
			write_reg(REG_DEADBAND, 16'(regs.deadband));
			write_reg(REG_LOOP_GAIN, 16'(regs.loop_gain));
			write_reg(REG_WAIT_PER_UNIT, 16'(regs.wait_per_unit));
			write_reg(REG_MANUAL_STEP, regs.manual_step);
			write_reg(REG_MIN_RUN_FREQUENCY, regs.min_run_frequency);
			write_reg(REG_BURST_THRESHOLD, regs.burst_threshold);

			// Pressure mostly hovers around a set point; ticks start near zero,
			// near the wrap or anywhere.
			press_center = $urandom_range(0, 32'(regs.max_target));
			case ($urandom_range(0, 2))
			0: cur_tick = $urandom_range(0, 100);
			1: cur_tick = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			default: cur_tick = $urandom;
			endcase

			repeat (ITEMS_PER_PHASE) begin
				// Ticks mostly creep forward, with occasional long jumps.
				pick = $urandom_range(0, 99);
				if (pick < 2)
					cur_tick = $urandom;
				else if (pick < 10)
					cur_tick += $urandom_range(0, 1 << 22);
				else if (pick < 30)
					cur_tick += $urandom_range(0, 5000);
				else
					cur_tick += $urandom_range(0, 60);
				pick = $urandom_range(0, 99);
				if (pick < 60)
					pa = 16'(press_center + $urandom_range(0, 16) - 8);
				else if (pick < 85)
					pa = 16'($urandom_range(0, 1300) - 150);
				else
					pa = 16'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 35)
					rep = 16'($urandom_range(0, 6000));
				else if (pick < 70)
					rep = 16'($urandom_range(0, 25000));
				else
					rep = 16'($urandom_range(0, 65535));
				send_pass(cur_tick, pa, rep, $urandom_range(0, 99) < 3,
					$urandom_range(0, 9) < 3, $urandom_range(0, 9) < 3,
					$urandom_range(0, 1) == 1);
			end
			settle_until_idle();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: fan_pressure_regulator.f
src/fpr_pkg.sv
src/fpr_if.sv
src/fpr_cfg.sv
src/fpr_core.sv
src/fan_pressure_regulator.sv
verif/fpr_loop_checker.sv
verif/testbench.sv
